>>> design/srarq_pkg.sv
`default_nettype none
package srarq_pkg;

  // Event codes on the input side.
  localparam logic [2:0] CMD_PKT_READY  = 3'd0;
  localparam logic [2:0] CMD_LINK_READY = 3'd1;
  localparam logic [2:0] CMD_FRAME_RX   = 3'd2;
  localparam logic [2:0] CMD_DATA_TMO   = 3'd3;
  localparam logic [2:0] CMD_ACK_TMO    = 3'd4;

  // Received frame kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // Action codes on the result side.
  localparam logic [2:0] ACT_SEND_DATA = 3'd0;
  localparam logic [2:0] ACT_SEND_ACK  = 3'd1;
  localparam logic [2:0] ACT_SEND_NAK  = 3'd2;
  localparam logic [2:0] ACT_STORE     = 3'd3;
  localparam logic [2:0] ACT_DELIVER   = 3'd4;
  localparam logic [2:0] ACT_STOP_TMR  = 3'd5;
  localparam logic [2:0] ACT_STATUS    = 3'd6;

  // Header plus checksum bytes stripped from a delivered frame.
  localparam int unsigned FrameOverhead = 7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LINK,
    OP_SEND_NEXT,
    OP_SEND_WANT,
    OP_SEND_OLD,
    OP_SEND_ACK,
    OP_SEND_NAK,
    OP_STORE,
    OP_DELIVER,
    OP_KCLR,
    OP_RELEASE,
    OP_SCAN,
    OP_STATUS
  } op_e;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_DISP   = 10'b00_0000_0010,
    ST_NAK    = 10'b00_0000_0100,
    ST_STORE  = 10'b00_0000_1000,
    ST_DLV    = 10'b00_0001_0000,
    ST_KCLR   = 10'b00_0010_0000,
    ST_REL    = 10'b00_0100_0000,
    ST_SCAN   = 10'b00_1000_0000,
    ST_RESEND = 10'b01_0000_0000,
    ST_STAT   = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       crc_ok;
    logic [1:0] kind;
    logic       nak_allowed;
    logic       rseq_ne_rb;
    logic       store_ok;
    logic       mark_rb;
    logic       k_lt_win;
    logic       rel_ok;
    logic       want_ok;
    logic       scan_last;
    logic       emit_ok;
  } stat_t;

endpackage
`default_nettype wire

>>> design/srarq_datapath.sv
`default_nettype none
module srarq_datapath #(
  parameter int unsigned SEQ_BITS = 5,
  parameter int unsigned AGE_BITS = 16,
  parameter int unsigned LEN_BITS = 11
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  srarq_pkg::ctrl_t         ctrl_i,
  output srarq_pkg::stat_t         stat_o,
  input  wire [2:0]                cmd_i,
  input  wire                      crc_ok_i,
  input  wire [1:0]                rx_kind_i,
  input  wire [SEQ_BITS-1:0]       rx_seq_i,
  input  wire [SEQ_BITS-1:0]       rx_ack_i,
  input  wire [LEN_BITS-1:0]       rx_len_i,
  input  wire                      out_ready_i,
  output logic                     out_valid_o,
  output logic [2:0]               action_o,
  output logic [SEQ_BITS-1:0]      seq_o,
  output logic [SEQ_BITS-1:0]      ack_o,
  output logic [SEQ_BITS-2:0]      slot_o,
  output logic [LEN_BITS-1:0]      pkt_len_o,
  output logic                     net_enable_o,
  output logic                     last_o
);

  localparam int unsigned SeqNum   = 1 << SEQ_BITS;
  localparam int unsigned Win      = SeqNum / 2;
  localparam int unsigned SlotBits = SEQ_BITS - 1;
  localparam logic [AGE_BITS-1:0] AgeMax = {AGE_BITS{1'b1}};
  localparam logic [SEQ_BITS-1:0] WinSeq = SEQ_BITS'(Win);
  localparam logic [SEQ_BITS-1:0] SeqOne = SEQ_BITS'(1);
  localparam logic [LEN_BITS-1:0] Ovh = LEN_BITS'(srarq_pkg::FrameOverhead);

  function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                     input logic [SEQ_BITS-1:0] b,
                                     input logic [SEQ_BITS-1:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

  function automatic logic [AGE_BITS-1:0] sat_inc(input logic [AGE_BITS-1:0] v);
    return (v == AgeMax) ? v : v + AGE_BITS'(1);
  endfunction

  logic [SEQ_BITS-1:0] nts_q, sb_q, rb_q, rl_q, outst_q;
  logic                nak_q, link_q;
  logic [Win-1:0]      mark_q;
  logic [SeqNum-1:0]   run_q;
  logic [AGE_BITS-1:0] age_q [SeqNum];
  logic [2:0]          cmd_q;
  logic                crc_q;
  logic [1:0]          kind_q;
  logic [SEQ_BITS-1:0] rseq_q, rack_q;
  logic [LEN_BITS-1:0] rlen_q;
  logic [SEQ_BITS-1:0] k_q;
  logic [SEQ_BITS-1:0] scan_q, best_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic                found_q;
  logic                out_vld_q;

  logic [SEQ_BITS-1:0] want, ack_out, send_seq;
  logic                is_send, restart, push, emit_ok;
  logic [2:0]          r_action;
  logic [SEQ_BITS-1:0] r_seq, r_ack;
  logic [SlotBits-1:0] r_slot;
  logic [LEN_BITS-1:0] r_len;
  logic                r_ne, r_last;

  assign want    = rack_q + SeqOne;
  assign ack_out = rb_q - SeqOne;
  assign emit_ok = !out_vld_q || out_ready_i;

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.crc_ok      = crc_q;
    stat_o.kind        = kind_q;
    stat_o.nak_allowed = nak_q;
    stat_o.rseq_ne_rb  = (rseq_q != rb_q);
    stat_o.store_ok    = in_window(rb_q, rseq_q, rl_q) && !mark_q[rseq_q[SlotBits-1:0]];
    stat_o.mark_rb     = mark_q[rb_q[SlotBits-1:0]];
    stat_o.k_lt_win    = (k_q < WinSeq);
    stat_o.rel_ok      = in_window(sb_q, rack_q, nts_q);
    stat_o.want_ok     = in_window(sb_q, want, nts_q);
    stat_o.scan_last   = (scan_q == {SEQ_BITS{1'b1}});
    stat_o.emit_ok     = emit_ok;
  end

  always_comb begin
    is_send  = 1'b0;
    restart  = 1'b0;
    send_seq = best_q;
    push     = 1'b1;
    r_action = srarq_pkg::ACT_STATUS;
    r_seq    = '0;
    r_ack    = '0;
    r_slot   = '0;
    r_len    = '0;
    r_ne     = 1'b0;
    r_last   = 1'b0;
    case (ctrl_i.op)
      srarq_pkg::OP_SEND_NEXT: begin
        is_send  = 1'b1;
        send_seq = nts_q;
      end
      srarq_pkg::OP_SEND_WANT: begin
        is_send  = 1'b1;
        send_seq = want;
      end
      srarq_pkg::OP_SEND_OLD: begin
        is_send = 1'b1;
        restart = 1'b1;
      end
      srarq_pkg::OP_SEND_ACK: begin
        r_action = srarq_pkg::ACT_SEND_ACK;
        r_ack    = ack_out;
      end
      srarq_pkg::OP_SEND_NAK: begin
        r_action = srarq_pkg::ACT_SEND_NAK;
        r_ack    = ack_out;
      end
      srarq_pkg::OP_STORE: begin
        r_action = srarq_pkg::ACT_STORE;
        r_seq    = rseq_q;
        r_slot   = rseq_q[SlotBits-1:0];
      end
      srarq_pkg::OP_DELIVER: begin
        r_action = srarq_pkg::ACT_DELIVER;
        r_seq    = rb_q;
        r_slot   = rb_q[SlotBits-1:0];
        r_len    = (rlen_q >= Ovh) ? rlen_q - Ovh : '0;
      end
      srarq_pkg::OP_RELEASE: begin
        r_action = srarq_pkg::ACT_STOP_TMR;
        r_seq    = sb_q;
      end
      srarq_pkg::OP_STATUS: begin
        r_ne   = !outst_q[SEQ_BITS-1] && link_q;
        r_last = 1'b1;
      end
      default: push = 1'b0;
    endcase
    if (is_send) begin
      push     = 1'b1;
      r_action = srarq_pkg::ACT_SEND_DATA;
      r_seq    = send_seq;
      r_ack    = ack_out;
      r_slot   = send_seq[SlotBits-1:0];
    end
  end

  // Link, window and receive state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nts_q   <= '0;
      sb_q    <= '0;
      rb_q    <= '0;
      rl_q    <= WinSeq;
      outst_q <= '0;
      nak_q   <= 1'b1;
      link_q  <= 1'b0;
      mark_q  <= '0;
      k_q     <= '0;
    end else begin
      if (is_send || ctrl_i.op == srarq_pkg::OP_SEND_ACK ||
          ctrl_i.op == srarq_pkg::OP_SEND_NAK) begin
        link_q <= 1'b0;
      end
      case (ctrl_i.op)
        srarq_pkg::OP_LATCH: k_q <= '0;
        srarq_pkg::OP_KCLR:  k_q <= '0;
        srarq_pkg::OP_LINK:  link_q <= 1'b1;
        srarq_pkg::OP_SEND_NEXT: begin
          nts_q   <= nts_q + SeqOne;
          outst_q <= outst_q + SeqOne;
        end
        srarq_pkg::OP_SEND_NAK: nak_q <= 1'b0;
        srarq_pkg::OP_STORE: mark_q[rseq_q[SlotBits-1:0]] <= 1'b1;
        srarq_pkg::OP_DELIVER: begin
          mark_q[rb_q[SlotBits-1:0]] <= 1'b0;
          nak_q <= 1'b1;
          rb_q  <= rb_q + SeqOne;
          rl_q  <= rl_q + SeqOne;
          k_q   <= k_q + SeqOne;
        end
        srarq_pkg::OP_RELEASE: begin
          sb_q    <= sb_q + SeqOne;
          outst_q <= outst_q - SeqOne;
          k_q     <= k_q + SeqOne;
        end
        default: ;
      endcase
    end
  end

  // Per-sequence timers: all running entries age together on each send.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      for (int i = 0; i < SeqNum; i++) age_q[i] <= '0;
    end else if (is_send) begin
      for (int i = 0; i < SeqNum; i++) begin
        if (SEQ_BITS'(i) == send_seq) begin
          run_q[i] <= 1'b1;
          if (restart || !run_q[i]) age_q[i] <= AGE_BITS'(1);
          else                      age_q[i] <= sat_inc(sat_inc(age_q[i]));
        end else if (run_q[i]) begin
          age_q[i] <= sat_inc(age_q[i]);
        end
      end
    end else if (ctrl_i.op == srarq_pkg::OP_RELEASE) begin
      run_q[sb_q] <= 1'b0;
      age_q[sb_q] <= '0;
    end
  end

  // Oldest-timer search, one entry per cycle; ties keep the lower sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.op == srarq_pkg::OP_LATCH) begin
      scan_q  <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.op == srarq_pkg::OP_SCAN) begin
      scan_q <= scan_q + SeqOne;
      if (run_q[scan_q] && (!found_q || age_q[scan_q] > best_age_q)) begin
        best_q  <= scan_q;
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == srarq_pkg::OP_SCAN && run_q[scan_q] &&
        (!found_q || age_q[scan_q] > best_age_q)) begin
      best_age_q <= age_q[scan_q];
    end
    if (ctrl_i.op == srarq_pkg::OP_LATCH) begin
      cmd_q  <= cmd_i;
      crc_q  <= crc_ok_i;
      kind_q <= rx_kind_i;
      rseq_q <= rx_seq_i;
      rack_q <= rx_ack_i;
      rlen_q <= rx_len_i;
    end
    if (push) begin
      action_o     <= r_action;
      seq_o        <= r_seq;
      ack_o        <= r_ack;
      slot_o       <= r_slot;
      pkt_len_o    <= r_len;
      net_enable_o <= r_ne;
      last_o       <= r_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= push || (out_vld_q && !out_ready_i);
  end

  assign out_valid_o = out_vld_q;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> emit_ok) else $error("result pushed over an untaken result");
  a_outst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q == nts_q - sb_q) else $error("outstanding count out of step");
  a_rx_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == srarq_pkg::OP_LATCH |-> !mark_q[rb_q[SlotBits-1:0]])
    else $error("in-order frame left undelivered");

endmodule
`default_nettype wire

>>> design/srarq_ctrl.sv
`default_nettype none
module srarq_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  srarq_pkg::stat_t  stat_i,
  output srarq_pkg::ctrl_t  ctrl_o
);

  srarq_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == srarq_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    ctrl_o.op  = srarq_pkg::OP_NONE;
    case (state_q)
      srarq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = srarq_pkg::OP_LATCH;
          state_d   = srarq_pkg::ST_DISP;
        end
      end
      srarq_pkg::ST_DISP: begin
        case (stat_i.cmd)
          srarq_pkg::CMD_PKT_READY: begin
            if (stat_i.emit_ok) begin
              ctrl_o.op = srarq_pkg::OP_SEND_NEXT;
              state_d   = srarq_pkg::ST_STAT;
            end
          end
          srarq_pkg::CMD_LINK_READY: begin
            ctrl_o.op = srarq_pkg::OP_LINK;
            state_d   = srarq_pkg::ST_STAT;
          end
          srarq_pkg::CMD_DATA_TMO: state_d = srarq_pkg::ST_SCAN;
          srarq_pkg::CMD_ACK_TMO: begin
            if (stat_i.emit_ok) begin
              ctrl_o.op = srarq_pkg::OP_SEND_ACK;
              state_d   = srarq_pkg::ST_STAT;
            end
          end
          srarq_pkg::CMD_FRAME_RX: begin
            if (!stat_i.crc_ok) begin
              if (!stat_i.nak_allowed) begin
                state_d = srarq_pkg::ST_STAT;
              end else if (stat_i.emit_ok) begin
                ctrl_o.op = srarq_pkg::OP_SEND_NAK;
                state_d   = srarq_pkg::ST_STAT;
              end
            end else if (stat_i.kind == srarq_pkg::KIND_DATA) begin
              state_d = srarq_pkg::ST_NAK;
            end else if (stat_i.kind == srarq_pkg::KIND_NAK && stat_i.want_ok) begin
              if (stat_i.emit_ok) begin
                ctrl_o.op = srarq_pkg::OP_SEND_WANT;
                state_d   = srarq_pkg::ST_KCLR;
              end
            end else begin
              state_d = srarq_pkg::ST_KCLR;
            end
          end
          default: state_d = srarq_pkg::ST_STAT;
        endcase
      end
      srarq_pkg::ST_NAK: begin
        if (!(stat_i.rseq_ne_rb && stat_i.nak_allowed)) begin
          state_d = srarq_pkg::ST_STORE;
        end else if (stat_i.emit_ok) begin
          ctrl_o.op = srarq_pkg::OP_SEND_NAK;
          state_d   = srarq_pkg::ST_STORE;
        end
      end
      srarq_pkg::ST_STORE: begin
        if (!stat_i.store_ok) begin
          state_d = srarq_pkg::ST_KCLR;
        end else if (stat_i.emit_ok) begin
          ctrl_o.op = srarq_pkg::OP_STORE;
          state_d   = srarq_pkg::ST_DLV;
        end
      end
      srarq_pkg::ST_DLV: begin
        if (!(stat_i.k_lt_win && stat_i.mark_rb)) begin
          state_d = srarq_pkg::ST_KCLR;
        end else if (stat_i.emit_ok) begin
          ctrl_o.op = srarq_pkg::OP_DELIVER;
        end
      end
      srarq_pkg::ST_KCLR: begin
        ctrl_o.op = srarq_pkg::OP_KCLR;
        state_d   = srarq_pkg::ST_REL;
      end
      srarq_pkg::ST_REL: begin
        if (!(stat_i.k_lt_win && stat_i.rel_ok)) begin
          state_d = srarq_pkg::ST_STAT;
        end else if (stat_i.emit_ok) begin
          ctrl_o.op = srarq_pkg::OP_RELEASE;
        end
      end
      srarq_pkg::ST_SCAN: begin
        ctrl_o.op = srarq_pkg::OP_SCAN;
        if (stat_i.scan_last) state_d = srarq_pkg::ST_RESEND;
      end
      srarq_pkg::ST_RESEND: begin
        if (stat_i.emit_ok) begin
          ctrl_o.op = srarq_pkg::OP_SEND_OLD;
          state_d   = srarq_pkg::ST_STAT;
        end
      end
      srarq_pkg::ST_STAT: begin
        if (stat_i.emit_ok) begin
          ctrl_o.op = srarq_pkg::OP_STATUS;
          state_d   = srarq_pkg::ST_IDLE;
        end
      end
      default: state_d = srarq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= srarq_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

>>> design/selective_repeat_arq_control.sv
// Timing: an event is taken in the idle state and its first result can be registered in the cycle
// after, at the earliest; each further result waits until the output register is free.
// A data timeout first walks all 2^SEQ_BITS timer ages (32 by default), one per cycle.
// Events are handled one at a time; a new item is taken only back in the idle state.
// Reset: rst_ni is asynchronous and active low; window and control state, marks and timers clear at once.
`default_nettype none
module selective_repeat_arq_control #(
  parameter int unsigned SEQ_BITS = 5,
  parameter int unsigned AGE_BITS = 16,
  parameter int unsigned LEN_BITS = 11
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // rx_seq, rx_ack, rx_len from bit 0 up, zero filled to whole bytes.
  input  wire [((2*SEQ_BITS+LEN_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd [2:0], crc_ok [3], rx_kind [5:4].
  input  wire [5:0]            s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  // seq, ack, slot, pkt_len, net_enable from bit 0 up, zero filled to whole bytes.
  output logic [((3*SEQ_BITS+LEN_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // action [2:0].
  output logic [2:0]           m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  localparam int unsigned InW  = ((2*SEQ_BITS+LEN_BITS+7)/8)*8;
  localparam int unsigned OutW = ((3*SEQ_BITS+LEN_BITS+7)/8)*8;
  localparam int unsigned OutUsed = 3*SEQ_BITS + LEN_BITS;

  srarq_pkg::ctrl_t ctrl;
  srarq_pkg::stat_t stat;

  logic [SEQ_BITS-1:0] seq, ack;
  logic [SEQ_BITS-2:0] slot;
  logic [LEN_BITS-1:0] pkt_len;
  logic                net_enable;
  logic [InW-1:0]      in_data;

  assign in_data = s_axis_tdata_i;

  // The controller sequences each event: it takes the item, then walks the scan, send,
  // NAK, store, deliver, release and status steps, at most one result per cycle whenever the
  // output register is free. The deliver and release loops stop after one window.
  srarq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The datapath holds the windows, arrival marks, timers and the output register.
  srarq_datapath #(
    .SEQ_BITS (SEQ_BITS),
    .AGE_BITS (AGE_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cmd_i        (s_axis_tuser_i[2:0]),
    .crc_ok_i     (s_axis_tuser_i[3]),
    .rx_kind_i    (s_axis_tuser_i[5:4]),
    .rx_seq_i     (in_data[SEQ_BITS-1:0]),
    .rx_ack_i     (in_data[2*SEQ_BITS-1:SEQ_BITS]),
    .rx_len_i     (in_data[2*SEQ_BITS+LEN_BITS-1:2*SEQ_BITS]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .action_o     (m_axis_tuser_o),
    .seq_o        (seq),
    .ack_o        (ack),
    .slot_o       (slot),
    .pkt_len_o    (pkt_len),
    .net_enable_o (net_enable),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutW'({net_enable, pkt_len, slot, ack, seq});

  // Only a status result closes an event.
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == srarq_pkg::ACT_STATUS)))
    else $error("tlast not tied to the status result");
  a_enable_only_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OutUsed-1] |-> m_axis_tlast_o)
    else $error("network enable set outside status");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o || m_axis_tlast_o)
    else $error("new item taken before the event ended");

endmodule
`default_nettype wire
